FILE: design/ckpt_pkg.sv
package ckpt_pkg;

  localparam int SLOTS_DEF   = 5;
  localparam int PAYLOAD_DEF = 256;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam int              CFG_ADDR_W      = 1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WIPE_ARMED = 1'b0;

  typedef enum logic [1:0] {
    REQ_CKPT     = 2'd0,
    REQ_ROLLBACK = 2'd1,
    REQ_VERIFY   = 2'd2,
    REQ_WIPE     = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SLOT  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_SIZE      = 3'd3,
    ST_NOT_ARMED = 3'd4,
    ST_OFFSET    = 3'd5
  } status_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [2:0]  slot_index;
    logic [7:0]  read_offset;
    logic [8:0]  capacity;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  written_slot;
    logic [31:0] seq_number;
    logic [8:0]  size_bytes;
    logic [7:0]  read_byte;
    logic        crc_ok;
    logic [2:0]  live_count;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic copy;
    logic verify;
    logic rd_fin;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic room;
    logic commit_go;
    logic verify_go;
    logic rd_go;
    logic walk_end;
  } stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: design/ckpt_in_if.sv
interface ckpt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [2:0] slot_index;
  logic [7:0] read_offset;
  logic [8:0] capacity;

  modport source (output valid, req_type, data_byte, last_byte, slot_index, read_offset,
                  capacity, input ready);
  modport sink (input valid, req_type, data_byte, last_byte, slot_index, read_offset,
                capacity, output ready);
endinterface

FILE: design/ckpt_out_if.sv
interface ckpt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  written_slot;
  logic [31:0] seq_number;
  logic [8:0]  size_bytes;
  logic [7:0]  read_byte;
  logic        crc_ok;
  logic [2:0]  live_count;

  modport source (output valid, status, written_slot, seq_number, size_bytes, read_byte,
                  crc_ok, live_count, input ready);
  modport sink (input valid, status, written_slot, seq_number, size_bytes, read_byte,
                crc_ok, live_count, output ready);
endinterface

FILE: design/checkpoint_slot_store_crc.sv
// Rotating checkpoint store: SLOTS slots of up to PAYLOAD_BYTES bytes each, with a
// reflected CRC-32 per slot. Every request word gives exactly one result word. A rollback
// hit does one registered read of the slot memory; a committing last byte and a verify
// walk the payload one byte per cycle through the single read port of a memory. A result
// passes through the registers done_r and out_r to the output; two results can wait
// there, so a new request is taken while one result is still unread. The wipe_armed
// register sits at byte address 0 of the APB port.
module checkpoint_slot_store_crc #(
  parameter int SLOTS         = ckpt_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BYTES = ckpt_pkg::PAYLOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ckpt_in_if.sink                         in_ch,
  ckpt_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ckpt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic            wipe_armed_r;
  ckpt_pkg::req_t  req;
  ckpt_pkg::res_t  res;
  ckpt_pkg::cmd_t  cmd;
  ckpt_pkg::stat_t st;
  logic            out_valid;

  // Configuration: zero-wait APB, single writable bit.
  assign pready = 1'b1;
  assign prdata = (paddr == ckpt_pkg::ADDR_WIPE_ARMED) ? {31'b0, wipe_armed_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wipe_armed_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == ckpt_pkg::ADDR_WIPE_ARMED)) begin
      wipe_armed_r <= pwdata[0];
    end
  end

  // Pack the request word for the datapath.
  always_comb begin
    req.req_type    = ckpt_pkg::req_type_t'(in_ch.req_type);
    req.data_byte   = in_ch.data_byte;
    req.last_byte   = in_ch.last_byte;
    req.slot_index  = in_ch.slot_index;
    req.read_offset = in_ch.read_offset;
    req.capacity    = in_ch.capacity;
  end

  // Sequencer: accept, then hold off new words while a commit or verify walks memory or a rollback hit reads it.
  ckpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st_i     (st),
    .cmd_o    (cmd)
  );

  // Staging buffer, slot memory, slot table, CRC units and the result stage.
  ckpt_dp #(
    .SLOTS         (SLOTS),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_i        (req),
    .wipe_armed_i (wipe_armed_r),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_valid),
    .res_o        (res)
  );

  // Unpack the result word onto the output channel.
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = res.status;
  assign out_ch.written_slot = res.written_slot;
  assign out_ch.seq_number   = res.seq_number;
  assign out_ch.size_bytes   = res.size_bytes;
  assign out_ch.read_byte    = res.read_byte;
  assign out_ch.crc_ok       = res.crc_ok;
  assign out_ch.live_count   = res.live_count;

endmodule

FILE: design/ckpt_ctrl.sv
module ckpt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ckpt_pkg::stat_t st_i,
  output ckpt_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_COPY = 4'b0100,
    S_VER  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd_o     = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = st_i.room;
        cmd_o.accept = in_valid && st_i.room;
        if (cmd_o.accept) begin
          priority if (st_i.commit_go) state_nxt = S_COPY;
          else if (st_i.verify_go)     state_nxt = S_VER;
          else if (st_i.rd_go)         state_nxt = S_RD;
          else                         state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.rd_fin = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (st_i.walk_end) begin
          cmd_o.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_VER: begin
        cmd_o.verify = 1'b1;
        if (st_i.walk_end) begin
          cmd_o.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/ckpt_dp.sv
module ckpt_dp #(
  parameter int SLOTS         = ckpt_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BYTES = ckpt_pkg::PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ckpt_pkg::req_t   req_i,
  input  logic             wipe_armed_i,
  input  ckpt_pkg::cmd_t   cmd_i,
  output ckpt_pkg::stat_t  st_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output ckpt_pkg::res_t   res_o
);

  localparam int AW   = $clog2(PAYLOAD_BYTES);
  localparam int CW   = $clog2(PAYLOAD_BYTES + 1);
  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MD   = SLOTS * PAYLOAD_BYTES;
  localparam int SAW  = $clog2(MD);
  localparam int CMPW = (CW > 9) ? CW : 9;
  localparam int LCW  = $clog2(SLOTS + 1);

  function automatic logic [SAW-1:0] slot_base(input logic [SW-1:0] s);
    return SAW'(s) * SAW'(PAYLOAD_BYTES);
  endfunction

  logic [7:0]  stg_mem  [PAYLOAD_BYTES];
  logic [7:0]  slot_mem [MD];
  logic [7:0]  stg_q_r, sm_q_r;

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic [31:0]    crc_r, crc_nxt;
  logic [SW-1:0]  wp_r, wp_nxt;
  logic [31:0]    seq_r, seq_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]  size_r [SLOTS];
  logic [CW-1:0]  size_nxt [SLOTS];
  logic [31:0]    scrc_r [SLOTS];
  logic [31:0]    scrc_nxt [SLOTS];

  logic [SW-1:0]  op_slot_r, op_slot_nxt;
  logic [CW-1:0]  op_len_r, op_len_nxt;
  logic [31:0]    op_crc_r, op_crc_nxt;
  logic [CW-1:0]  walk_r, walk_nxt;
  logic           rd_v_r, rd_v_nxt;
  logic [AW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [31:0]    vcrc_r, vcrc_nxt;

  logic           done_v_r, out_v_r;
  ckpt_pkg::res_t done_r, out_r, res_nxt;
  logic           res_ld, out_free;

  logic           stg_we, sm_we;
  logic [AW-1:0]  stg_wa, stg_ra;
  logic [SAW-1:0] sm_wa, sm_ra;

  // request decode
  logic [SW-1:0]  rslot;
  logic           bad, empty, cap_small, off_big, has_room, ovf_eff;
  logic [CW-1:0]  rsize, cnt_inc;
  logic [31:0]    crc_step, vcrc_step, vcrc_fin;
  logic [LCW-1:0] lc;

  assign out_free = !out_v_r || out_ready_i;
  assign rslot    = req_i.slot_index[SW-1:0];
  assign bad      = ({29'b0, req_i.slot_index} >= 32'(SLOTS));
  assign empty    = bad ? 1'b1 : !valid_r[rslot];
  assign rsize    = bad ? '0 : size_r[rslot];
  assign cap_small = CMPW'(req_i.capacity) < CMPW'(rsize);
  assign off_big   = CMPW'(req_i.read_offset) >= CMPW'(rsize);
  assign has_room  = cnt_r < CW'(PAYLOAD_BYTES);
  assign ovf_eff   = ovf_r || !has_room;
  assign cnt_inc   = cnt_r + CW'(1);
  assign crc_step  = ckpt_pkg::crc_byte(crc_r, req_i.data_byte);
  assign vcrc_step = ckpt_pkg::crc_byte(vcrc_r, sm_q_r);
  assign vcrc_fin  = rd_v_r ? vcrc_step : vcrc_r;

  always_comb begin
    st_o.room      = !done_v_r || out_free;
    st_o.commit_go = (req_i.req_type == ckpt_pkg::REQ_CKPT) && req_i.last_byte && !ovf_eff;
    st_o.verify_go = (req_i.req_type == ckpt_pkg::REQ_VERIFY) && !bad && !empty;
    st_o.rd_go     = (req_i.req_type == ckpt_pkg::REQ_ROLLBACK) && !bad && !empty &&
                     !cap_small && !off_big;
    st_o.walk_end  = (walk_r == op_len_r);
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    crc_nxt     = crc_r;
    wp_nxt      = wp_r;
    seq_nxt     = seq_r;
    valid_nxt   = valid_r;
    size_nxt    = size_r;
    scrc_nxt    = scrc_r;
    op_slot_nxt = op_slot_r;
    op_len_nxt  = op_len_r;
    op_crc_nxt  = op_crc_r;
    walk_nxt    = walk_r;
    rd_v_nxt    = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    vcrc_nxt    = vcrc_r;
    stg_we      = 1'b0;
    stg_wa      = cnt_r[AW-1:0];
    stg_ra      = walk_r[AW-1:0];
    sm_we       = 1'b0;
    sm_wa       = slot_base(op_slot_r) + SAW'(rd_idx_r);
    sm_ra       = slot_base(rslot) + SAW'(req_i.read_offset);
    res_ld      = 1'b0;
    res_nxt     = '0;
    res_nxt.status = ckpt_pkg::ST_OK;
    lc          = '0;

    if (cmd_i.accept) begin
      walk_nxt = '0;
      unique case (req_i.req_type)
        ckpt_pkg::REQ_CKPT: begin
          if (has_room) begin
            stg_we  = 1'b1;
            cnt_nxt = cnt_inc;
            crc_nxt = crc_step;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (req_i.last_byte) begin
            if (ovf_eff) begin
              res_nxt.status = ckpt_pkg::ST_SIZE;
              res_ld         = 1'b1;
            end else begin
              op_slot_nxt = wp_r;
              op_len_nxt  = cnt_inc;
              op_crc_nxt  = ~crc_step;
            end
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            crc_nxt = ckpt_pkg::CRC_INIT;
          end else begin
            res_ld = 1'b1;
          end
        end
        ckpt_pkg::REQ_ROLLBACK, ckpt_pkg::REQ_VERIFY: begin
          if (bad) begin
            res_nxt.status = ckpt_pkg::ST_BAD_SLOT;
            res_ld         = 1'b1;
          end else if (empty) begin
            res_nxt.status = ckpt_pkg::ST_EMPTY;
            res_ld         = 1'b1;
          end else if (req_i.req_type == ckpt_pkg::REQ_ROLLBACK) begin
            res_nxt.size_bytes = 9'(rsize);
            op_len_nxt         = rsize;
            if (cap_small) begin
              res_nxt.status = ckpt_pkg::ST_SIZE;
              res_ld         = 1'b1;
            end else if (off_big) begin
              res_nxt.status = ckpt_pkg::ST_OFFSET;
              res_ld         = 1'b1;
            end
          end else begin
            op_slot_nxt = rslot;
            op_len_nxt  = rsize;
            vcrc_nxt    = ckpt_pkg::CRC_INIT;
          end
        end
        ckpt_pkg::REQ_WIPE: begin
          res_ld = 1'b1;
          if (!wipe_armed_i) begin
            res_nxt.status = ckpt_pkg::ST_NOT_ARMED;
          end else begin
            valid_nxt = '0;
            wp_nxt    = '0;
          end
        end
      endcase
    end

    if (cmd_i.copy || cmd_i.verify) begin
      if (walk_r < op_len_r) begin
        walk_nxt   = walk_r + CW'(1);
        rd_v_nxt   = 1'b1;
        rd_idx_nxt = walk_r[AW-1:0];
      end
    end

    if (cmd_i.copy) begin
      sm_we = rd_v_r;
      if (cmd_i.fin) begin
        valid_nxt[op_slot_r] = 1'b1;
        size_nxt[op_slot_r]  = op_len_r;
        scrc_nxt[op_slot_r]  = op_crc_r;
        seq_nxt              = seq_r + 32'd1;
        wp_nxt               = (wp_r == SW'(SLOTS - 1)) ? '0 : wp_r + SW'(1);
        res_nxt.written_slot = 3'(op_slot_r);
        res_nxt.seq_number   = seq_r;
        res_nxt.size_bytes   = 9'(op_len_r);
        res_ld               = 1'b1;
      end
    end

    if (cmd_i.verify) begin
      sm_ra = slot_base(op_slot_r) + SAW'(walk_r);
      if (rd_v_r) vcrc_nxt = vcrc_step;
      if (cmd_i.fin) begin
        res_nxt.size_bytes = 9'(op_len_r);
        res_nxt.crc_ok     = (~vcrc_fin == scrc_r[op_slot_r]);
        res_ld             = 1'b1;
      end
    end

    if (cmd_i.rd_fin) begin
      res_nxt.size_bytes = 9'(op_len_r);
      res_nxt.read_byte  = sm_q_r;
      res_ld             = 1'b1;
    end

    for (int i = 0; i < SLOTS; i++) begin
      lc = lc + LCW'(valid_nxt[i]);
    end
    res_nxt.live_count = 3'(lc);
  end

  always_ff @(posedge clk) begin
    if (stg_we) stg_mem[stg_wa] <= req_i.data_byte;
    stg_q_r <= stg_mem[stg_ra];
  end

  always_ff @(posedge clk) begin
    if (sm_we) slot_mem[sm_wa] <= stg_q_r;
    sm_q_r <= slot_mem[sm_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      crc_r    <= ckpt_pkg::CRC_INIT;
      wp_r     <= '0;
      seq_r    <= '0;
      valid_r  <= '0;
      walk_r   <= '0;
      rd_v_r   <= 1'b0;
      done_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      crc_r   <= crc_nxt;
      wp_r    <= wp_nxt;
      seq_r   <= seq_nxt;
      valid_r <= valid_nxt;
      walk_r  <= walk_nxt;
      rd_v_r  <= rd_v_nxt;
      if (res_ld)        done_v_r <= 1'b1;
      else if (out_free) done_v_r <= 1'b0;
      if (out_free)      out_v_r  <= done_v_r;
    end
  end

  always_ff @(posedge clk) begin
    size_r    <= size_nxt;
    scrc_r    <= scrc_nxt;
    op_slot_r <= op_slot_nxt;
    op_len_r  <= op_len_nxt;
    op_crc_r  <= op_crc_nxt;
    rd_idx_r  <= rd_idx_nxt;
    vcrc_r    <= vcrc_nxt;
    if (res_ld) done_r <= res_nxt;
    if (out_free && done_v_r) out_r <= done_r;
  end

  assign out_valid_o = out_v_r;
  assign res_o       = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_ld |-> (!done_v_r || out_free))
    else $error("result buffer overwritten");

  a_fin_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.fin |-> rd_v_r)
    else $error("walk ended without last read in flight");

  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(PAYLOAD_BYTES))
    else $error("staging count beyond buffer");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(wp_r) < SLOTS)
    else $error("write pointer out of range");

endmodule
